// File: sv/sedq_pkg.sv
// ============================================================================
// Sorted event deadline queue package
// Shared widths, default parameter values and command codes.
// ============================================================================
package sedq_pkg;

   // Default values for the top-level parameters.
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_TAG_WIDTH   = 8;

   // Fixed field widths.
   localparam int DEADLINE_WIDTH = 64;
   localparam int DELAY_WIDTH    = 32;

   // Request command codes.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

endpackage

// File: sv/sedq_store.sv
// ============================================================================
// Sorted event deadline queue entry store
// Deadline and tag memories with one write port and one registered read port.
// ============================================================================
module sedq_store #(
   parameter int QUEUE_DEPTH = sedq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TAG_WIDTH   = sedq_pkg::DEFAULT_TAG_WIDTH
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]      wr_addr,
   input  logic [sedq_pkg::DEADLINE_WIDTH-1:0] wr_deadline,
   input  logic [TAG_WIDTH-1:0]                wr_tag,
   input  logic                                rd_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
   output logic [sedq_pkg::DEADLINE_WIDTH-1:0] rd_deadline,
   output logic [TAG_WIDTH-1:0]                rd_tag
);

   logic [sedq_pkg::DEADLINE_WIDTH-1:0] deadline_mem [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0]                tag_mem      [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         deadline_mem[wr_addr] <= wr_deadline;
         tag_mem[wr_addr]      <= wr_tag;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_deadline <= deadline_mem[rd_addr];
         rd_tag      <= tag_mem[rd_addr];
      end
   end

endmodule

// File: sv/sorted_event_deadline_queue.sv
// ============================================================================
// Sorted event deadline queue
// Timer event queue kept in ascending deadline order in a circular memory.
// ============================================================================
// The queue holds up to QUEUE_DEPTH pending events, each a 64-bit deadline
// and a tag, in ascending order of deadline. An insert transaction computes
// now + delay (wrapping modulo 2^64); an equal-or-earlier deadline than the
// head goes in front of the head, otherwise the event goes behind every entry
// whose deadline is less than or equal to its own. A remove transaction drops
// the head and is ignored on an empty queue; an insert into a full queue is
// rejected with accepted low. Every request produces exactly one response
// transaction with the resulting head, count and empty flag. The entries live
// in a circular buffer in one synchronous memory, so a remove just advances
// the head pointer, while an insert walks from the tail toward the head,
// reading one entry and moving it up by one slot per cycle. A remove or a
// rejected insert only passes through HEAD_RD and FIN, while a stored insert
// first walks over the entries it moves up, one at a time through the single
// memory read port. A finished response waits in an output register, so the
// next request is taken while it is still stalled.
// ============================================================================
module sorted_event_deadline_queue #(
   parameter int QUEUE_DEPTH = sedq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TAG_WIDTH   = sedq_pkg::DEFAULT_TAG_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_command,
   input  logic [sedq_pkg::DEADLINE_WIDTH-1:0]    req_now,
   input  logic [sedq_pkg::DELAY_WIDTH-1:0]       req_delay,
   input  logic [TAG_WIDTH-1:0]                   req_event_tag,
   // Response channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic [sedq_pkg::DEADLINE_WIDTH-1:0]    rsp_new_deadline,
   output logic                                   rsp_queue_empty,
   output logic [sedq_pkg::DEADLINE_WIDTH-1:0]    rsp_head_deadline,
   output logic [TAG_WIDTH-1:0]                   rsp_head_tag,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_pending_count
);

   // Address width of the circular buffer and width of the entry count.
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = sedq_pkg::DEADLINE_WIDTH;
   localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);

   // Controller states. WALK reads one entry per cycle from the tail toward
   // the head and moves it up while it belongs behind the new event. PLACE
   // writes the new event at the head slot. HEAD_RD fetches the resulting
   // head for the response, and FIN loads the response register.
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_WALK    = 5'b00010,
      S_PLACE   = 5'b00100,
      S_HEAD_RD = 5'b01000,
      S_FIN     = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     head_ptr_ff, head_ptr_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [DW-1:0]     new_deadline_ff, new_deadline_in;
   logic [TAG_WIDTH-1:0] new_tag_ff, new_tag_in;
   logic              accepted_ff, accepted_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff;
   logic [DW-1:0]     rsp_new_deadline_ff;
   logic              rsp_queue_empty_ff;
   logic [DW-1:0]     rsp_head_deadline_ff;
   logic [TAG_WIDTH-1:0] rsp_head_tag_ff;
   logic [CW-1:0]     rsp_pending_count_ff;
   logic              rsp_load;

   // Memory ports.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DW-1:0]     wr_deadline;
   logic [TAG_WIDTH-1:0] wr_tag;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DW-1:0]     rd_deadline;
   logic [TAG_WIDTH-1:0] rd_tag;

   logic [CW-1:0]     count_m1;
   logic [AW-1:0]     idx_p1;
   logic [AW-1:0]     idx_m1;
   logic [AW-1:0]     head_next;
   logic              move_up;

   // Logical position to physical memory address, modulo the depth.
   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                               input logic [AW-1:0] offset);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[AW-1:0];
   endfunction

   sedq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) u_store (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_deadline (wr_deadline),
      .wr_tag      (wr_tag),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_deadline (rd_deadline),
      .rd_tag      (rd_tag)
   );

   assign count_m1  = count_ff - CW'(1);
   assign idx_p1    = idx_ff + AW'(1);
   assign idx_m1    = idx_ff - AW'(1);
   assign head_next = (head_ptr_ff == LAST_ADDR) ? '0 : head_ptr_ff + AW'(1);

   // When the new deadline is equal to or earlier than the head's, the new
   // event goes in front of the head, so every entry moves up, including
   // entries that share the head's deadline. Otherwise an entry moves up only
   // when it is strictly later. A walk only runs on a nonempty queue, after
   // the previous response was loaded, so the response register still holds
   // the current head deadline.
   assign move_up = (new_deadline_ff <= rsp_head_deadline_ff) ||
                    (new_deadline_ff <  rd_deadline);

   // A request is taken only while the controller is idle.
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      head_ptr_in     = head_ptr_ff;
      idx_in          = idx_ff;
      new_deadline_in = new_deadline_ff;
      new_tag_in      = new_tag_ff;
      accepted_in     = accepted_ff;
      wr_en           = 1'b0;
      wr_addr         = head_ptr_ff;
      wr_deadline     = rd_deadline;
      wr_tag          = rd_tag;
      rd_en           = 1'b0;
      rd_addr         = head_ptr_ff;
      rsp_load        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_tag_in = req_event_tag;
               if (req_command == sedq_pkg::CMD_INSERT) begin
                  new_deadline_in = req_now + DW'(req_delay);
                  if (count_ff == DEPTH_CNT) begin
                     // Full queue: reject and report the unchanged head.
                     accepted_in = 1'b0;
                     state_in    = S_HEAD_RD;
                  end else if (count_ff == '0) begin
                     accepted_in = 1'b1;
                     state_in    = S_PLACE;
                  end else begin
                     // Start the walk at the tail entry.
                     accepted_in = 1'b1;
                     idx_in      = count_m1[AW-1:0];
                     rd_en       = 1'b1;
                     rd_addr     = phys_addr(head_ptr_ff, count_m1[AW-1:0]);
                     state_in    = S_WALK;
                  end
               end else begin
                  new_deadline_in = '0;
                  state_in        = S_HEAD_RD;
                  if (count_ff != '0) begin
                     accepted_in = 1'b1;
                     count_in    = count_m1;
                     head_ptr_in = head_next;
                  end else begin
                     accepted_in = 1'b0;
                  end
               end
            end
         end
         S_WALK: begin
            wr_en   = 1'b1;
            wr_addr = phys_addr(head_ptr_ff, idx_p1);
            if (move_up) begin
               // Move the entry up one slot; the next read is two slots
               // below this write, so the two never collide.
               if (idx_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  idx_in  = idx_m1;
                  rd_en   = 1'b1;
                  rd_addr = phys_addr(head_ptr_ff, idx_m1);
               end
            end else begin
               // The slot above this entry is free for the new event.
               wr_deadline = new_deadline_ff;
               wr_tag      = new_tag_ff;
               count_in    = count_ff + CW'(1);
               state_in    = S_HEAD_RD;
            end
         end
         S_PLACE: begin
            wr_en       = 1'b1;
            wr_addr     = head_ptr_ff;
            wr_deadline = new_deadline_ff;
            wr_tag      = new_tag_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ptr_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            // The head read data holds until the response register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ptr_ff  <= head_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      new_deadline_ff <= new_deadline_in;
      new_tag_ff      <= new_tag_in;
      accepted_ff     <= accepted_in;
      if (rsp_load) begin
         rsp_accepted_ff      <= accepted_ff;
         rsp_new_deadline_ff  <= new_deadline_ff;
         rsp_queue_empty_ff   <= (count_ff == '0);
         rsp_head_deadline_ff <= (count_ff == '0) ? '0 : rd_deadline;
         rsp_head_tag_ff      <= (count_ff == '0) ? '0 : rd_tag;
         rsp_pending_count_ff <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_new_deadline  = rsp_new_deadline_ff;
   assign rsp_queue_empty   = rsp_queue_empty_ff;
   assign rsp_head_deadline = rsp_head_deadline_ff;
   assign rsp_head_tag      = rsp_head_tag_ff;
   assign rsp_pending_count = rsp_pending_count_ff;

   // The entry count never exceeds the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count exceeds queue depth");

   // The walk only visits stored entries.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (idx_ff < count_ff))
      else $error("walk index beyond stored entries");

   // A write never lands on the slot being read in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("memory read and write collide");

   // An empty report carries a zero head and a zero count.
   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_empty) |->
         (rsp_pending_count == '0 && rsp_head_deadline == '0 && rsp_head_tag == '0))
      else $error("empty response with nonzero head or count");

   // Every response load is followed by a held response until it is taken.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pending_count)))
      else $error("stalled response lost or changed");

endmodule
